@@ hdl/dqb_pkg.sv @@
package dqb_pkg;

  localparam int MAX_LABEL   = 63;
  localparam int STORE_DEPTH = 63;
  localparam int CNT_W       = 6;
  localparam int ADDR_W      = 6;
  localparam int STEP_W      = 4;
  localparam int HDR_BYTES   = 12;
  localparam int TRL_BYTES   = 5;

  localparam logic [7:0]  DOT_CHAR        = 8'h2E;
  localparam logic [15:0] QUERY_IDENT_RST = 16'd1234;
  localparam logic        WANT_RECUR_RST  = 1'b1;

  localparam logic [1:0] OP_BEGIN    = 2'd0;
  localparam logic [1:0] OP_CHAR     = 2'd1;
  localparam logic [1:0] OP_END      = 2'd2;
  localparam logic [1:0] OP_QUESTION = 2'd3;

  localparam logic [2:0] KIND_A     = 3'd0;
  localparam logic [2:0] KIND_NS    = 3'd1;
  localparam logic [2:0] KIND_CNAME = 3'd2;
  localparam logic [2:0] KIND_AAAA  = 3'd3;

  localparam logic [1:0] CMD_HDR   = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_TRL   = 2'd3;

  localparam logic REG_QUERY_IDENT = 1'b0;
  localparam logic REG_WANT_RECUR  = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] name_char;
    logic [2:0] query_kind;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       label_too_long;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] kind_code(input logic [2:0] kind);
    logic [7:0] code;
    case (kind)
      KIND_A:     code = 8'd1;
      KIND_NS:    code = 8'd2;
      KIND_CNAME: code = 8'd5;
      KIND_AAAA:  code = 8'd28;
      default:    code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/dqb_cmd_fifo.sv @@
module dqb_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  dqb_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output dqb_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import dqb_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/dqb_front.sv @@
module dqb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dqb_pkg::in_item_t in_data,
  input  logic              cmd_pop,
  output dqb_pkg::cmd_t     cmd,
  output logic              cmd_empty
);
  import dqb_pkg::*;

  cmd_t cmd_in;

  always_comb begin
    cmd_in.data = in_data.name_char;
    case (in_data.op)
      OP_BEGIN: cmd_in.kind = CMD_HDR;
      OP_CHAR:  cmd_in.kind = (in_data.name_char == DOT_CHAR) ? CMD_FLUSH : CMD_CHAR;
      OP_END:   cmd_in.kind = CMD_FLUSH;
      default: begin
        cmd_in.kind = CMD_TRL;
        cmd_in.data = kind_code(in_data.query_kind);
      end
    endcase
  end

  dqb_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_cmd (cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd),
    .empty  (cmd_empty)
  );

endmodule

@@ hdl/dqb_back.sv @@
module dqb_back (
  input  logic               clk,
  input  logic               rst,
  input  dqb_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic [15:0]        query_ident,
  input  logic               want_recursion,
  output logic               empty,
  input  logic               pop,
  output dqb_pkg::out_item_t out_data
);
  import dqb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_TRL  = 3'd4;

  logic [2:0]        state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  label_count;
  logic              overflow_seen;
  logic [ADDR_W-1:0] idx;
  logic [7:0]        code;
  logic [7:0]        label_store [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic              out_valid;

  logic              can_emit;
  logic              emit;
  out_item_t         item;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [7:0]        hdr_byte;
  logic [7:0]        trl_byte;

  assign can_emit = !out_valid || pop;
  assign empty    = !out_valid;
  assign wr_en    = cmd_pop && (cmd.kind == CMD_CHAR) &&
                    (label_count < CNT_W'(MAX_LABEL));

  always_comb begin
    case (step)
      4'd0:    hdr_byte = query_ident[15:8];
      4'd1:    hdr_byte = query_ident[7:0];
      4'd2:    hdr_byte = {7'd0, want_recursion};
      4'd5:    hdr_byte = 8'd1;
      default: hdr_byte = 8'd0;
    endcase
    case (step)
      4'd2:    trl_byte = code;
      4'd4:    trl_byte = 8'd1;
      default: trl_byte = 8'd0;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    emit    = 1'b0;
    item    = '0;
    rd_en   = 1'b0;
    rd_addr = idx + ADDR_W'(1);
    case (state)
      ST_IDLE: cmd_pop = !cmd_empty;
      ST_HDR: begin
        emit          = can_emit;
        item.out_byte = hdr_byte;
        item.run_last = (step == STEP_W'(HDR_BYTES - 1));
      end
      ST_TRL: begin
        emit          = can_emit;
        item.out_byte = trl_byte;
        item.run_last = (step == STEP_W'(TRL_BYTES - 1));
      end
      ST_LEN: begin
        emit                = can_emit;
        item.out_byte       = {2'd0, label_count};
        item.run_last       = (label_count == '0);
        item.label_too_long = overflow_seen;
        rd_en               = can_emit && (label_count != '0);
        rd_addr             = '0;
      end
      ST_DATA: begin
        emit                = can_emit;
        item.out_byte       = rd_data;
        item.run_last       = ((idx + ADDR_W'(1)) == label_count);
        item.label_too_long = overflow_seen;
        rd_en               = can_emit && !item.run_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_store[label_count] <= cmd.data;
    end
    if (rd_en) begin
      rd_data <= label_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      idx           <= '0;
      code          <= '0;
      label_count   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            step <= '0;
            case (cmd.kind)
              CMD_HDR: begin
                label_count   <= '0;
                overflow_seen <= 1'b0;
                state         <= ST_HDR;
              end
              CMD_CHAR: begin
                if (wr_en) begin
                  label_count <= label_count + CNT_W'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              CMD_FLUSH: state <= ST_LEN;
              default: begin
                code  <= cmd.data;
                state <= ST_TRL;
              end
            endcase
          end
        end
        ST_HDR, ST_TRL: begin
          if (emit) begin
            step <= step + STEP_W'(1);
            if (item.run_last) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_LEN: begin
          if (emit) begin
            idx <= '0;
            if (item.run_last) begin
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              state <= ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (emit) begin
            idx <= idx + ADDR_W'(1);
            if (item.run_last) begin
              label_count   <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/dns_query_builder_top.sv @@
// Channel   Handshake            Payload
// input     push / full          in_data  (op, name_char, query_kind)
// result    pop / empty          out_data (out_byte, run_last, label_too_long)
// config    psel/penable/pwrite  paddr 0 query_ident, paddr 4 want_recursion
//
// Each item passes through a two-entry command queue and then a byte sequencer.
// A begin item emits 12 bytes, a question 5, and a label flush 1 + length bytes,
// one byte per cycle while the result is popped, once the item is taken from the queue.
// Label bytes are read from a single-port store with registered read data.
// Reset is synchronous; it empties the queue and the output and clears the label.
// A stalled result holds; the queue keeps taking items until it is full.
module dns_query_builder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  dqb_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output dqb_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dqb_pkg::*;

  logic [15:0] query_ident;
  logic        want_recursion;
  logic        cfg_write;
  cmd_t        cmd;
  logic        cmd_empty;
  logic        cmd_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_ident    <= QUERY_IDENT_RST;
      want_recursion <= WANT_RECUR_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_QUERY_IDENT) begin
        query_ident <= pwdata[15:0];
      end else begin
        want_recursion <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WANT_RECUR) begin
      prdata = {31'd0, want_recursion};
    end else begin
      prdata = {16'd0, query_ident};
    end
  end

  dqb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  dqb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .query_ident    (query_ident),
    .want_recursion (want_recursion),
    .empty          (empty),
    .pop            (pop),
    .out_data       (out_data)
  );

endmodule
